FILE: hw/rtl/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg: shared types and constants for the tilt angle EMA block
// Payload words, sequencer states, fixed widths and the CORDIC arctangent
// table in degrees, Q16.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int ANGLE_W       = 16;
    localparam int WEIGHT_W      = 16;
    localparam int RAD_W         = 32;
    localparam int ROOT_W        = 16;
    localparam int CORDIC_W      = 36;
    localparam int ACC_W         = 25;
    localparam int MUL_W         = 18;
    localparam int PROD_W        = 36;
    localparam int SUM_W         = 37;
    localparam int ATAN_ENTRIES  = 24;
    localparam int ATAN_IDX_W    = 5;
    localparam int ATAN_W        = 22;
    localparam int DEG_LIMIT_Q88 = 23040;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;
    // register index, taken from the word address bit of paddr
    localparam logic REG_IDX_WEIGHT = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic signed [SAMPLE_W-1:0] z_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] raw_tilt;
        logic signed [ANGLE_W-1:0] smoothed_tilt;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Z,
        ST_ROOT_GO,
        ST_ROOT,
        ST_CORDIC,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_C
    } seq_state_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 22'd2949120;
                5'd1:    val = 22'd1740967;
                5'd2:    val = 22'd919879;
                5'd3:    val = 22'd466945;
                5'd4:    val = 22'd234379;
                5'd5:    val = 22'd117305;
                5'd6:    val = 22'd58666;
                5'd7:    val = 22'd29335;
                5'd8:    val = 22'd14668;
                5'd9:    val = 22'd7334;
                5'd10:   val = 22'd3667;
                5'd11:   val = 22'd1833;
                5'd12:   val = 22'd917;
                5'd13:   val = 22'd458;
                5'd14:   val = 22'd229;
                5'd15:   val = 22'd115;
                5'd16:   val = 22'd57;
                5'd17:   val = 22'd29;
                5'd18:   val = 22'd14;
                5'd19:   val = 22'd7;
                5'd20:   val = 22'd4;
                5'd21:   val = 22'd2;
                5'd22:   val = 22'd1;
                default: val = 22'd0;
            endcase
            return val;
        end
    endfunction

endpackage

FILE: hw/rtl/tae_sqrt.sv
// ----------------------------------------------------------------------------
// tae_sqrt: iterative integer square root
// Bit-pair restoring method, one trial subtract per cycle. Gives
// floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module tae_sqrt
    import tae_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEPS = RAD_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RAD_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0] bit_val;
    logic [RAD_W-1:0] trial;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // one trial subtraction per cycle
    always_comb
    begin
        bit_val   = {2'b01, {(RAD_W-2){1'b0}}} >> {cnt_reg, 1'b0};
        trial     = root_reg + bit_val;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = radicand;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

FILE: hw/rtl/tae_cordic.sv
// ----------------------------------------------------------------------------
// tae_cordic: vectoring CORDIC, one micro-rotation per cycle
// Drives y toward zero and accumulates the angle in degrees Q16, then rounds
// to Q8.8 and clamps to +/-90 degrees.
// ----------------------------------------------------------------------------
module tae_cordic
    import tae_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ROOT_W-1:0]          radius,
    input  logic signed [SAMPLE_W-1:0] y_in,
    output logic                       done,
    output logic signed [ANGLE_W-1:0]  angle
);

    localparam int CNT_W = $clog2(STEPS);
    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(DEG_LIMIT_Q88);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(DEG_LIMIT_Q88);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [CORDIC_W-1:0] cx_reg, cx_next;
    logic signed [CORDIC_W-1:0] cy_reg, cy_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ACC_W-1:0]    atan_term;
    logic signed [ACC_W-1:0]    acc_round;
    logic signed [ACC_W-1:0]    q_wide;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        acc_reg <= acc_next;
    end

    // micro-rotation: shifts floor toward minus infinity
    always_comb
    begin
        dx        = cy_reg >>> cnt_reg;
        dy        = cx_reg >>> cnt_reg;
        atan_term = signed'({{(ACC_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(cnt_reg))});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            cx_next   = signed'(CORDIC_W'({radius, 16'h0000}));
            cy_next   = CORDIC_W'(y_in) <<< 16;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!cy_reg[CORDIC_W-1])
            begin
                cx_next  = cx_reg + dx;
                cy_next  = cy_reg - dy;
                acc_next = acc_reg + atan_term;
            end
            else
            begin
                cx_next  = cx_reg - dx;
                cy_next  = cy_reg + dy;
                acc_next = acc_reg - atan_term;
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Q16 -> Q8.8 with round half up, then clamp
    always_comb
    begin
        acc_round = acc_reg + ROUND_HALF;
        q_wide    = acc_round >>> 8;
        if (q_wide > LIM_POS)
        begin
            angle = ANGLE_W'(LIM_POS);
        end
        else if (q_wide < LIM_NEG)
        begin
            angle = ANGLE_W'(LIM_NEG);
        end
        else
        begin
            angle = ANGLE_W'(q_wide);
        end
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/tilt_angle_ema.sv
// The square root and the CORDIC rotation loop run back to back; a word
// with a zero Y axis skips both. A new word is taken only once the previous
// result has been committed to the output register.
// Reset: clears the sequencer, the output valid, the smoothed angle (0 deg)
//   and sets the smoothing weight to 6554.
// ----------------------------------------------------------------------------
// tilt_angle_ema: accelerometer tilt angle with exponential smoothing
// Squares through one shared multiplier, iterative square root, vectoring
// CORDIC, then an EMA through the same multiplier. One word at a time.
// ----------------------------------------------------------------------------
module tilt_angle_ema
    import tae_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    localparam int STEPS_EFF =
        (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic signed [SUM_W-1:0] EMA_HALF = SUM_W'(32768);
    localparam logic [WEIGHT_W:0] WEIGHT_ONE = {1'b1, {WEIGHT_W{1'b0}}};

    seq_state_t state_reg, state_next;

    logic [WEIGHT_W-1:0]        weight_reg, weight_next;
    logic signed [ANGLE_W-1:0]  last_reg, last_next;
    logic                       out_valid_reg, out_valid_next;
    out_word_t                  out_data_reg, out_data_next;
    in_word_t                   sample_reg, sample_next;
    logic signed [ANGLE_W-1:0]  raw_reg, raw_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;

    logic                       cfg_write;
    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic [WEIGHT_W:0]          weight_comp;
    logic signed [SUM_W-1:0]    ema_sum;
    logic signed [SUM_W-1:0]    ema_shift;
    logic signed [ANGLE_W-1:0]  smoothed;
    logic                       commit;

    logic                       sqrt_start, sqrt_done;
    logic [RAD_W-1:0]           radicand;
    logic [ROOT_W-1:0]          root;
    logic                       cordic_start, cordic_done;
    logic signed [ANGLE_W-1:0]  cordic_angle;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == REG_IDX_WEIGHT);
    assign weight_next = cfg_write ? pwdata[WEIGHT_W-1:0] : weight_reg;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_WEIGHT)
                    ? APB_DATA_W'(weight_reg) : '0;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            weight_reg    <= WEIGHT_RESET;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            weight_reg    <= weight_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        raw_reg      <= raw_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    // shared multiplier operand select
    assign weight_comp = WEIGHT_ONE - {1'b0, weight_reg};

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_SQ_X:
            begin
                mul_a = MUL_W'(sample_reg.x_sample);
                mul_b = MUL_W'(sample_reg.x_sample);
            end
            ST_SQ_Z:
            begin
                mul_a = MUL_W'(sample_reg.z_sample);
                mul_b = MUL_W'(sample_reg.z_sample);
            end
            ST_EMA_A:
            begin
                mul_a = signed'({2'b00, weight_reg});
                mul_b = MUL_W'(raw_reg);
            end
            ST_EMA_B:
            begin
                mul_a = signed'({1'b0, weight_comp});
                mul_b = MUL_W'(last_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = mul_en ? PROD_W'(mul_a * mul_b) : prod_reg;

    // EMA rounding: floor((sum + 2^15) / 2^16)
    assign ema_sum   = sum_reg + SUM_W'(prod_reg) + EMA_HALF;
    assign ema_shift = ema_sum >>> 16;
    assign smoothed  = ANGLE_W'(ema_shift);
    assign commit    = (state_reg == ST_EMA_C) && (!out_valid_reg || !out_stall);

    assign radicand = RAD_W'(sum_reg + SUM_W'(prod_reg));

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        raw_next      = raw_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        out_data_next = out_data_reg;
        sqrt_start    = 1'b0;
        cordic_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_data;
                    state_next  = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z:
            begin
                sum_next   = SUM_W'(prod_reg);
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                // level Y axis: angle is exactly zero
                if (sample_reg.y_sample == '0)
                begin
                    raw_next   = '0;
                    state_next = ST_EMA_A;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    raw_next   = cordic_angle;
                    state_next = ST_EMA_A;
                end
            end
            ST_EMA_A:
            begin
                state_next = ST_EMA_B;
            end
            ST_EMA_B:
            begin
                sum_next   = SUM_W'(prod_reg);
                state_next = ST_EMA_C;
            end
            ST_EMA_C:
            begin
                if (commit)
                begin
                    last_next                   = smoothed;
                    out_data_next.raw_tilt      = raw_reg;
                    out_data_next.smoothed_tilt = smoothed;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tae_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    tae_cordic #(
        .STEPS (STEPS_EFF)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .radius (root),
        .y_in   (sample_reg.y_sample),
        .done   (cordic_done),
        .angle  (cordic_angle)
    );

endmodule

FILE: hw/rtl/tae_checker.sv
// ----------------------------------------------------------------------------
// tae_checker: port-level checks for tilt_angle_ema
// Watches the word channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module tae_checker
    import tae_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without work in progress");

    // both angles stay within +/-90 degrees
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.raw_tilt <= DEG_LIMIT_Q88)
                   && (out_data.raw_tilt >= -DEG_LIMIT_Q88)
                   && (out_data.smoothed_tilt <= DEG_LIMIT_Q88)
                   && (out_data.smoothed_tilt >= -DEG_LIMIT_Q88))
        else $error("tilt angle out of range");

endmodule

bind tilt_angle_ema tae_checker u_tae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tilt angle EMA block
// Feeds accelerometer words through a valid/stall driver, predicts the raw
// and smoothed tilt of each accepted word and checks every output word in
// order. The smoothing weight is changed over the APB port between phases,
// and both sides idle at varying rates.
// ----------------------------------------------------------------------------
module testbench;
    import tae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS         = 16;
    localparam int LATENCY       = STEPS + 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int PRINT_CAP     = 40;
    localparam logic [APB_ADDR_W-1:0] WEIGHT_ADDR = 3'd0;
    // word address of a register index that does not exist
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = 3'd4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;

    // bench-side copy of the block's state and setting
    logic [WEIGHT_W-1:0]       weight_q16 = WEIGHT_RESET;
    logic signed [ANGLE_W-1:0] last_smoothed_q88 = '0;

    in_word_t  sample_queue [$];
    out_word_t tilt_expected [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // atan(2^-i) in degrees, Q16
    longint atan_deg_q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    tilt_angle_ema #(
        .CORDIC_STEPS(STEPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch: %s", what);
    endtask

    // bitwise integer square root, floor
    function automatic int unsigned floor_sqrt(input int unsigned value);
        int unsigned rem;
        int unsigned root;
        int unsigned probe;
        rem   = value;
        root  = 0;
        probe = 32'd1 << 30;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // atan2(y, sqrt(x^2+z^2)) by vectoring CORDIC, degrees Q8.8
    function automatic logic signed [ANGLE_W-1:0] tilt_from_sample(
        input logic signed [SAMPLE_W-1:0] xs,
        input logic signed [SAMPLE_W-1:0] ys,
        input logic signed [SAMPLE_W-1:0] zs
    );
        int          sx;
        int          sz;
        int unsigned radius_sq;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        longint      angle;
        longint      q;
        int          steps_used;
        if (ys == 0)
            return '0;
        sx         = xs;
        sz         = zs;
        radius_sq  = int'(unsigned'(sx * sx)) + int'(unsigned'(sz * sz));
        cx         = longint'(floor_sqrt(radius_sq)) * 65536;
        cy         = longint'(ys) * 65536;
        angle      = 0;
        steps_used = (STEPS > 24) ? 24 : STEPS;
        for (int i = 0; i < steps_used; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx    += dx;
                cy    -= dy;
                angle += atan_deg_q16[i];
            end
            else
            begin
                cx    -= dx;
                cy    += dy;
                angle -= atan_deg_q16[i];
            end
        end
        q = (angle + 128) >>> 8;
        if (q > DEG_LIMIT_Q88)
            q = DEG_LIMIT_Q88;
        if (q < -DEG_LIMIT_Q88)
            q = -DEG_LIMIT_Q88;
        return q[ANGLE_W-1:0];
    endfunction

    // w*raw + (1-w)*last, rounded half up
    function automatic logic signed [ANGLE_W-1:0] ema_update(
        input logic signed [ANGLE_W-1:0] raw,
        input logic signed [ANGLE_W-1:0] last,
        input logic [WEIGHT_W-1:0]       w
    );
        longint acc;
        acc = longint'(w) * longint'(raw) + (65536 - longint'(w)) * longint'(last);
        acc = (acc + 32768) >>> 16;
        return acc[ANGLE_W-1:0];
    endfunction

    task automatic predict_word(input in_word_t word);
        out_word_t want;
        want.raw_tilt      = tilt_from_sample(word.x_sample, word.y_sample, word.z_sample);
        want.smoothed_tilt = ema_update(want.raw_tilt, last_smoothed_q88, weight_q16);
        last_smoothed_q88  = want.smoothed_tilt;
        tilt_expected.push_back(want);
    endtask

    function automatic in_word_t make_sample(
        input int xv,
        input int yv,
        input int zv
    );
        in_word_t w;
        w.x_sample = xv[SAMPLE_W-1:0];
        w.y_sample = yv[SAMPLE_W-1:0];
        w.z_sample = zv[SAMPLE_W-1:0];
        return w;
    endfunction

    // mix of full-range, small, level, vertical and extreme samples
    function automatic in_word_t random_sample();
        in_word_t w;
        int       pick;
        pick = $urandom_range(0, 99);
        w.x_sample = SAMPLE_W'($urandom);
        w.y_sample = SAMPLE_W'($urandom);
        w.z_sample = SAMPLE_W'($urandom);
        if (pick < 50)
            ;
        else if (pick < 65)
            w = make_sample($urandom_range(0, 127) - 64, $urandom_range(0, 127) - 64,
                            $urandom_range(0, 127) - 64);
        else if (pick < 75)
            w.y_sample = '0;
        else if (pick < 85)
        begin
            w.x_sample = '0;
            w.z_sample = '0;
            if (w.y_sample == 0)
                w.y_sample = 16'sd1;
        end
        else if (pick < 92)
        begin
            case ($urandom_range(0, 2))
                0:       w.x_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                1:       w.y_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                default: w.z_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            endcase
        end
        else
            w = make_sample($urandom_range(0, 15) - 8, $urandom_range(0, 65535) - 32768,
                            $urandom_range(0, 15) - 8);
        return w;
    endfunction

    // driver: present queued words, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_word(in_data);
            if (!in_valid || !in_stall)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= sample_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random stall, compare each taken word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tilt_expected.size() == 0)
                    report_mismatch($sformatf("unexpected word raw=%0d smooth=%0d",
                                              out_data.raw_tilt, out_data.smoothed_tilt));
                else
                begin
                    out_word_t want;
                    want = tilt_expected.pop_front();
                    if (out_data.raw_tilt !== want.raw_tilt)
                        report_mismatch($sformatf("raw_tilt got %0d want %0d",
                                                  out_data.raw_tilt, want.raw_tilt));
                    if (out_data.smoothed_tilt !== want.smoothed_tilt)
                        report_mismatch($sformatf("smoothed_tilt got %0d want %0d",
                                                  out_data.smoothed_tilt, want.smoothed_tilt));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // cycles in a row with no transfer on any port
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    task automatic reg_write(
        input logic [APB_ADDR_W-1:0] addr,
        input logic [APB_DATA_W-1:0] data
    );
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic weight_readback(input logic [WEIGHT_W-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WEIGHT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[WEIGHT_W-1:0] !== want)
            report_mismatch($sformatf("weight read %0d want %0d",
                                      prdata[WEIGHT_W-1:0], want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_random(input int count);
        repeat (count)
            sample_queue.push_back(random_sample());
    endtask

    // wait until every word is out, then past the pipeline depth
    task automatic drain();
        while (sample_queue.size() != 0 || in_valid || tilt_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8)
            @(negedge clk);
    endtask

    task automatic set_weight(input logic [WEIGHT_W-1:0] w);
        reg_write(WEIGHT_ADDR, {{(APB_DATA_W-WEIGHT_W){1'b0}}, w});
        weight_q16 = w;
        weight_readback(w);
    endtask

    initial
    begin
        logic [WEIGHT_W-1:0] phase_weight [0:5];
        int                  phase_count  [0:5];
        phase_weight = '{16'hffff, 16'h0000, 16'h0001, 16'h8000, 16'h0000, WEIGHT_RESET};
        phase_count  = '{450, 150, 350, 300, 350, 330};
        phase_weight[4] = WEIGHT_W'($urandom_range(0, 65535));

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset weight, then directed corners
        weight_readback(WEIGHT_RESET);
        send_idle_pct = 13;
        recv_idle_pct = 58;
        // all zero, then level samples with zero y
        sample_queue.push_back(make_sample(0, 0, 0));
        sample_queue.push_back(make_sample(32767, 0, 32767));
        sample_queue.push_back(make_sample(-32768, 0, -32768));
        // pure vertical: x and z zero
        sample_queue.push_back(make_sample(0, 1, 0));
        sample_queue.push_back(make_sample(0, -1, 0));
        sample_queue.push_back(make_sample(0, 32767, 0));
        sample_queue.push_back(make_sample(0, -32768, 0));
        // axis extremes
        sample_queue.push_back(make_sample(-32768, -32768, -32768));
        sample_queue.push_back(make_sample(32767, 32767, 32767));
        sample_queue.push_back(make_sample(-32768, 32767, -32768));
        sample_queue.push_back(make_sample(32767, -32768, 32767));
        sample_queue.push_back(make_sample(0, -32768, -32768));
        // small and mixed values
        sample_queue.push_back(make_sample(1, 1, 1));
        sample_queue.push_back(make_sample(1, -1, 0));
        sample_queue.push_back(make_sample(-1, -1, -1));
        sample_queue.push_back(make_sample(0, 0, 5));
        sample_queue.push_back(make_sample(0, 16384, 16384));
        sample_queue.push_back(make_sample(16384, -16384, 0));
        sample_queue.push_back(make_sample(100, 200, -300));
        sample_queue.push_back(make_sample(12345, -6789, -2222));
        drain();

        for (int p = 0; p < 6; p++)
        begin
            set_weight(phase_weight[p]);
            // a write to a missing register leaves the weight alone
            if (p == 2)
            begin
                reg_write(SPARE_ADDR, $urandom);
                weight_readback(weight_q16);
            end
            case (p)
                0, 1:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 58;
                end
                2, 3:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 0)
            begin
                // sender holds off until the block has emptied
                load_random(phase_count[p] / 2);
                drain();
                load_random(phase_count[p] - phase_count[p] / 2);
            end
            else
                load_random(phase_count[p]);
            drain();
        end

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
